FILE: src/polynomial_evaluator_defines.svh
// Assertion macros for the polynomial evaluator.
// Each macro wraps one concurrent assertion; synthesis builds see empty bodies.
`ifndef POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define POLYNOMIAL_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define PE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polynomial_evaluator: assertion failed");
// ante implies cons a fixed number of cycles later
`define PE_ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("polynomial_evaluator: assertion failed");
`else
`define PE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PE_ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons)
`endif

`endif

FILE: src/pe_pkg.sv
`default_nettype none

package pe_pkg;

    localparam int ORDER_DEF = 7;
    localparam int NUM_COEFS = 8;
    localparam int COEF_W    = 16;
    localparam int POINT_W   = 16;
    localparam int ACC_W     = 32;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = ACC_W + POINT_W;
    localparam int CFG_IDX_W = $clog2(NUM_COEFS);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NUM_COEFS-1:0] t_coef_bank;

    // one word moving down the Horner chain
    typedef struct packed {
        logic                      valid;
        logic signed [POINT_W-1:0] point;
        logic signed [ACC_W-1:0]   acc;
        logic                      ovf;
    } t_stage;

endpackage

`default_nettype wire

FILE: src/pe_coef_bank.sv
`default_nettype none

module pe_coef_bank (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [pe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [pe_pkg::COEF_W-1:0]        i_cfg_data,
    output pe_pkg::t_coef_bank               o_coef
);

    pe_pkg::t_coef_bank r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

FILE: src/pe_horner_step.sv
`default_nettype none

// One Horner step over two register stages:
// stage A multiplies acc * x, stage B shifts, clamps, adds the coefficient, clamps.
module pe_horner_step (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire pe_pkg::t_stage i_stage,
    input  wire pe_pkg::t_coef  i_coef,
    output pe_pkg::t_stage      o_stage
);

    localparam int SH_W  = pe_pkg::PROD_W - pe_pkg::FRAC_BITS;
    localparam int ACC_W = pe_pkg::ACC_W;
    localparam int EXT_W = ACC_W + 1;

    // stage A
    logic                              r_a_valid;
    logic signed [pe_pkg::POINT_W-1:0] r_a_point;
    logic                              r_a_ovf;
    logic signed [pe_pkg::PROD_W-1:0]  r_prod;
    logic signed [pe_pkg::PROD_W-1:0]  n_prod;

    // stage B
    logic                              r_b_valid;
    logic signed [pe_pkg::POINT_W-1:0] r_b_point;
    logic                              r_b_ovf;
    logic signed [ACC_W-1:0]           r_b_acc;

    logic signed [SH_W-1:0]  shifted;
    logic                    prod_ovf;
    logic signed [ACC_W-1:0] prod_sat;
    logic signed [EXT_W-1:0] sum;
    logic                    sum_ovf;
    logic signed [ACC_W-1:0] n_acc;

    assign n_prod = $signed(i_stage.acc) * $signed(i_stage.point);

    // arithmetic shift right = drop fraction bits (floor)
    assign shifted  = r_prod[pe_pkg::PROD_W-1:pe_pkg::FRAC_BITS];
    assign prod_ovf = !((&shifted[SH_W-1:ACC_W-1]) || !(|shifted[SH_W-1:ACC_W-1]));
    assign prod_sat = prod_ovf ? (shifted[SH_W-1] ? pe_pkg::ACC_MIN : pe_pkg::ACC_MAX)
                               : shifted[ACC_W-1:0];
    assign sum      = {prod_sat[ACC_W-1], prod_sat}
                    + {{(EXT_W-pe_pkg::COEF_W){i_coef[pe_pkg::COEF_W-1]}}, i_coef};
    assign sum_ovf  = sum[EXT_W-1] ^ sum[ACC_W-1];
    assign n_acc    = sum_ovf ? (sum[EXT_W-1] ? pe_pkg::ACC_MIN : pe_pkg::ACC_MAX)
                              : sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_stage.valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_point <= i_stage.point;
        r_a_ovf   <= i_stage.ovf;
        r_prod    <= n_prod;
        r_b_point <= r_a_point;
        r_b_ovf   <= r_a_ovf | prod_ovf | sum_ovf;
        r_b_acc   <= n_acc;
    end

    assign o_stage.valid = r_b_valid;
    assign o_stage.point = r_b_point;
    assign o_stage.acc   = r_b_acc;
    assign o_stage.ovf   = r_b_ovf;

endmodule

`default_nettype wire

FILE: src/polynomial_evaluator.sv
`default_nettype none
// Polynomial evaluator, Horner's rule in signed fixed point.
//
// Channels:
//   Input  - a word (i_point, Q4.12) is taken on a rising edge with start high and
//            busy low. busy is only high while reset is held.
//   Output - o_valid strobes for one cycle with o_value (Q20.12, saturated) and
//            o_overflow (set if any product or sum of the chain clamped).
//   Config - i_cfg_we writes i_cfg_data into coefficient i_cfg_index (coef_0 is the
//            constant term). Write only while no word is in flight.
// From accept to o_valid a word passes through ORDER Horner steps. Each Horner
// step is two register stages: a 32x16 multiply, then shift/clamp/add/clamp.
// Throughput: one word per cycle, set by the fully pipelined step chain.
// Reset (synchronous, active low) clears the coefficients and all in-flight
// valid bits; words in flight are dropped. The receiver cannot stall, so the
// pipeline never holds and a result is presented exactly once.
`include "polynomial_evaluator_defines.svh"

module polynomial_evaluator #(
    parameter int ORDER = pe_pkg::ORDER_DEF   // 1..7
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  signed [pe_pkg::POINT_W-1:0] i_point,
    input  wire                              i_cfg_we,
    input  wire  [pe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [pe_pkg::COEF_W-1:0]        i_cfg_data,
    output logic                             o_valid,
    output logic signed [pe_pkg::ACC_W-1:0]  o_value,
    output logic                             o_overflow
);

    localparam int LATENCY = 2 * ORDER;

    pe_pkg::t_coef_bank coef;
    pe_pkg::t_stage     chain [ORDER:0];
    logic               accept;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    pe_coef_bank u_coef_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    // chain head: accumulator seeded with the top coefficient, sign-extended
    assign chain[0].valid = accept;
    assign chain[0].point = i_point;
    assign chain[0].acc   = {{(pe_pkg::ACC_W-pe_pkg::COEF_W){coef[ORDER][pe_pkg::COEF_W-1]}},
                             coef[ORDER]};
    assign chain[0].ovf   = 1'b0;

    // step g folds in coef_(ORDER-1-g)
    for (genvar g = 0; g < ORDER; g++) begin : g_step
        pe_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .i_coef  (coef[ORDER-1-g]),
            .o_stage (chain[g+1])
        );
    end

    // last step's stage B registers drive the result ports directly
    assign o_valid    = chain[ORDER].valid;
    assign o_value    = chain[ORDER].acc;
    assign o_overflow = chain[ORDER].ovf;

    // every accepted word comes out after the fixed latency, and nothing else does
    `PE_ASSERT_DELAYED(a_accept_to_result, i_clk, i_rst_n, accept, LATENCY, o_valid)
    `PE_ASSERT_IMPLY(a_result_from_accept, i_clk, i_rst_n, o_valid, $past(accept, LATENCY))

endmodule

`default_nettype wire
